// ===== hw/rtl/stepper_full_step_drive_defines.svh =====
// assertion macros shared by the stepper drive rtl
// needs a clock named clk and an active-high reset named rst in the using module
`ifndef STEPPER_FULL_STEP_DRIVE_DEFINES_SVH
`define STEPPER_FULL_STEP_DRIVE_DEFINES_SVH

// same-cycle implication, skipped during reset
`define STP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, skipped during reset
`define STP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/stp_pkg.sv =====
// shared types and constants for the stepper full-step drive
// no dependencies
package stp_pkg;

  // drive modes carried in s_tuser
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_FWD  = 2'd1;
  localparam logic [1:0] MODE_REV  = 2'd2;

  // how the back end finds the speed readout
  localparam logic [1:0] SPD_ZERO = 2'd0;
  localparam logic [1:0] SPD_SLOW = 2'd1;
  localparam logic [1:0] SPD_DIV  = 2'd2;

  // period rules
  localparam logic [11:0] SLOW_LIMIT  = 12'd80;
  localparam logic [15:0] SLOW_PERIOD = 16'd50000;
  localparam logic [15:0] BASE_PERIOD = 16'd36000;
  localparam logic [15:0] CAP_SUB     = 16'd33000;
  // reciprocal of ten in 16 fractional bits, exact for 12-bit samples
  localparam logic [12:0] RECIP_TEN   = 13'd6554;

  // speed rules
  localparam logic [23:0] SPD_NUM    = 24'(3276800 * 60 / 20);
  localparam logic [11:0] SLOW_SPEED = 12'd200;
  localparam logic [11:0] SPD_MAX    = 12'd3276;
  localparam int          DIV_STEPS  = 12;

  localparam int QUEUE_DEPTH = 2;

  // one classified step between front and back
  typedef struct packed {
    logic [1:0]  speed_kind;
    logic [15:0] period;
    logic        awake;
    logic [3:0]  coils;   // a_in1, a_in2, b_in1, b_in2 from msb down
  } stp_entry_t;

  // full-step bridge pattern for a phase
  function automatic logic [3:0] coil_pattern(input logic [1:0] phase);
    logic [3:0] pat;
    case (phase)
      2'd0: pat = 4'b1010;
      2'd1: pat = 4'b0110;
      2'd2: pat = 4'b0101;
      2'd3: pat = 4'b1001;
      default: pat = 4'b0000;
    endcase
    return pat;
  endfunction

endpackage

// ===== hw/rtl/stp_front.sv =====
// front end: accepts step beats, keeps phase counters and the held period
// depends on stp_pkg
module stp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [1:0]        s_tuser,   // drive_mode
  input  logic [15:0]       s_tdata,   // pot_sample [11:0], zeros above
  output logic              push,
  output stp_pkg::stp_entry_t push_data,
  input  logic              full
);
  import stp_pkg::*;

  logic [1:0]  fwd_phase;
  logic [1:0]  rev_phase;
  logic [15:0] held_period;

  logic [1:0]  mode;
  logic [11:0] sample;
  logic        drive;
  logic        is_fwd;
  logic        slow;
  logic [24:0] recip_prod;
  logic [8:0]  tens;
  logic [15:0] sub;
  logic [15:0] sub_cap;
  logic [15:0] period;

  assign mode   = s_tuser;
  assign sample = s_tdata[11:0];
  assign drive  = (mode == MODE_FWD) || (mode == MODE_REV);
  assign is_fwd = (mode == MODE_FWD);

  assign s_tready = !full;
  assign push     = s_tvalid && s_tready;

  // period from the sample: tens via reciprocal, times 100 by shifts, capped
  assign slow       = sample < SLOW_LIMIT;
  assign recip_prod = {13'd0, sample} * {12'd0, RECIP_TEN};
  assign tens       = recip_prod[24:16];
  assign sub        = {1'b0, tens, 6'd0} + {2'b0, tens, 5'd0} + {5'b0, tens, 2'd0};
  assign sub_cap    = (sub > CAP_SUB) ? CAP_SUB : sub;
  assign period     = slow ? SLOW_PERIOD : (BASE_PERIOD - sub_cap);

  // classify the beat for the back end
  always_comb begin
    push_data.coils      = 4'b0000;
    push_data.awake      = 1'b0;
    push_data.period     = held_period;
    push_data.speed_kind = SPD_ZERO;
    if (drive) begin
      push_data.coils      = coil_pattern(is_fwd ? fwd_phase : rev_phase);
      push_data.awake      = 1'b1;
      push_data.period     = period;
      push_data.speed_kind = slow ? SPD_SLOW : SPD_DIV;
    end
  end

  // phase counters and held period advance on driving beats
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_phase   <= 2'd0;
      rev_phase   <= 2'd0;
      held_period <= 16'd0;
    end else if (push && drive) begin
      held_period <= period;
      if (is_fwd) begin
        fwd_phase <= fwd_phase - 2'd1;
      end else begin
        rev_phase <= rev_phase + 2'd1;
      end
    end
  end

endmodule

// ===== hw/rtl/stp_fifo.sv =====
// short queue of classified steps between front and back end
// depends on stp_pkg and the assertion macros
`include "stepper_full_step_drive_defines.svh"
module stp_fifo #(
  parameter int DEPTH = stp_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  stp_pkg::stp_entry_t push_data,
  output logic                full,
  input  logic                pop,
  output stp_pkg::stp_entry_t pop_data,
  output logic                empty
);
  import stp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  stp_entry_t        slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `STP_ASSERT_IMP(a_no_overflow, push, !full, "push into a full queue")
  `STP_ASSERT_IMP(a_no_underflow, pop, !empty, "pop from an empty queue")
  `STP_ASSERT_IMP(a_count_range, 1'b1, count <= CNT_W'(DEPTH), "queue count out of range")

endmodule

// ===== hw/rtl/stp_back.sv =====
// back end: speed divider and output register for step results
// depends on stp_pkg and the assertion macros
`include "stepper_full_step_drive_defines.svh"
module stp_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                empty,
  output logic                pop,
  input  stp_pkg::stp_entry_t pop_data,
  output logic                m_tvalid,
  input  logic                m_tready,
  // coil_a_in1, coil_a_in2, coil_b_in1, coil_b_in2, driver_awake,
  // step_period [20:5], speed_rpm_x100 [32:21], zeros above
  output logic [39:0]         m_tdata
);
  import stp_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]  state;
  stp_entry_t  job;
  logic [11:0] quot;
  logic [15:0] rem;
  logic [11:0] num_low;
  logic [3:0]  div_cnt;

  logic [3:0]  out_coils;
  logic        out_awake;
  logic [15:0] out_period;
  logic [11:0] out_speed;

  logic        out_free;
  logic        out_load;
  logic [16:0] trial;
  logic        fits;

  assign out_free = !m_tvalid || m_tready;
  assign out_load = (state == ST_DONE) && out_free;
  assign pop      = (state == ST_IDLE) && !empty;

  // one quotient bit per cycle
  assign trial = {rem, num_low[11]};
  assign fits  = trial >= {1'b0, job.period};

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      div_cnt  <= 4'd0;
    end else begin
      // result beat valid: set on load, cleared once taken
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!empty) begin
            job     <= pop_data;
            rem     <= {4'd0, SPD_NUM[23:12]};
            num_low <= SPD_NUM[11:0];
            div_cnt <= 4'd0;
            quot    <= (pop_data.speed_kind == SPD_SLOW) ? SLOW_SPEED : 12'd0;
            state   <= (pop_data.speed_kind == SPD_DIV) ? ST_DIV : ST_DONE;
          end
        end
        ST_DIV: begin
          rem     <= fits ? 16'(trial - {1'b0, job.period}) : trial[15:0];
          quot    <= {quot[10:0], fits};
          num_low <= {num_low[10:0], 1'b0};
          div_cnt <= div_cnt + 4'd1;
          if (div_cnt == 4'(DIV_STEPS - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_coils  <= job.coils;
            out_awake  <= job.awake;
            out_period <= job.period;
            out_speed  <= quot;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result beat packing
  assign m_tdata = {7'd0, out_speed, out_period, out_awake,
                    out_coils[0], out_coils[1], out_coils[2], out_coils[3]};

  `STP_ASSERT_IMP(a_sleep_quiet, m_tvalid && !out_awake, (out_coils == 4'b0000) && (out_speed == 12'd0), "sleeping beat drives coils or speed")
  `STP_ASSERT_IMP(a_speed_max, m_tvalid, out_speed <= SPD_MAX, "speed readout above range")
  `STP_ASSERT_NEXT(a_div_exit, (state == ST_DIV) && (div_cnt == 4'(DIV_STEPS - 1)), state == ST_DONE, "divider did not finish")

endmodule

// ===== hw/rtl/stepper_full_step_drive.sv =====
// top level of the bipolar stepper full-step drive
// depends on stp_pkg, stp_front, stp_fifo and stp_back
//
// One input beat per step tick gives a drive mode (s_tuser) and a 12-bit pot
// sample; one result beat returns the four bridge levels, the driver wake bit,
// the step timer period and the speed readout. The front end takes a beat
// whenever the queue has room. The back end skips the divider for idle or slow
// steps; a normal step runs the bit-serial divider, which forms 9830400/period
// one quotient bit per cycle; the back end takes no new beat from the queue
// until the last result is loaded. A queue of QUEUE_DEPTH entries lets input
// beats be taken while results wait on m_tready.
module stepper_full_step_drive #(
  parameter int QUEUE_DEPTH = stp_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,   // drive_mode
  input  logic [15:0] s_tdata,   // pot_sample [11:0], zeros above
  output logic        m_tvalid,
  input  logic        m_tready,
  // coil_a_in1, coil_a_in2, coil_b_in1, coil_b_in2, driver_awake,
  // step_period [20:5], speed_rpm_x100 [32:21], zeros above
  output logic [39:0] m_tdata
);
  import stp_pkg::*;

  logic       push;
  logic       full;
  logic       pop;
  logic       empty;
  stp_entry_t push_data;
  stp_entry_t pop_data;

  // classify incoming step beats
  stp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  // decoupling queue
  stp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  // speed divide and result output
  stp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .pop      (pop),
    .pop_data (pop_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== tb/sv/tb_stepper_full_step_drive.sv =====
// testbench for stepper_full_step_drive: streams step ticks in, checks every result beat
// against an in-bench model of the phase counters, period and speed math; needs stp_pkg
module tb_stepper_full_step_drive;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_SPARE = 2'd3;   // unused mode, behaves as idle
  localparam int unsigned RUN_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned LONG_HOLD = 300;

  typedef struct {
    logic [1:0]  mode;
    logic [11:0] sample;
    bit          drain_first;   // wait for all results before offering
  } step_tick_t;

  typedef struct {
    bit          a_in1;
    bit          a_in2;
    bit          b_in1;
    bit          b_in2;
    bit          awake;
    logic [15:0] period;
    logic [11:0] speed;
  } drive_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [1:0]  s_tuser = '0;     // drive_mode
  logic [15:0] s_tdata = '0;     // pot_sample [11:0], zeros above
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // coil_a_in1, coil_a_in2, coil_b_in1, coil_b_in2, driver_awake,
  // step_period [20:5], speed_rpm_x100 [32:21]
  logic [39:0] m_tdata;

  step_tick_t  pending_ticks[$];
  drive_out_t  expected_drive[$];

  int unsigned tx_gap_pct = 28;
  int unsigned rx_stall_pct = 55;
  int unsigned rx_hold_requests = 0;
  int unsigned rx_hold_taken = 0;
  int unsigned rx_hold_left = 0;
  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;

  // model state
  logic [1:0]  fwd_phase = 2'd0;
  logic [1:0]  rev_phase = 2'd0;
  logic [15:0] held_period = 16'd0;

  stepper_full_step_drive uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // bridge levels a_in1, a_in2, b_in1, b_in2 from msb down
  function automatic logic [3:0] full_step_coils(input logic [1:0] phase);
    case (phase)
      2'd0: return 4'b1010;
      2'd1: return 4'b0110;
      2'd2: return 4'b0101;
      default: return 4'b1001;
    endcase
  endfunction

  // expected result of one step tick; advances the phase counters and held period
  function automatic drive_out_t predict_drive(input logic [1:0] mode,
                                               input logic [11:0] sample);
    drive_out_t  res;
    logic [3:0]  coils;
    int unsigned sub;
    int unsigned per;
    coils = 4'b0000;
    res.awake = 1'b0;
    res.speed = '0;
    if (mode == stp_pkg::MODE_FWD || mode == stp_pkg::MODE_REV) begin
      if (sample < 80) begin
        per = 50000;
        res.speed = 12'd200;
      end else begin
        sub = (sample / 10) * 100;
        if (sub > 33000) sub = 33000;
        per = 36000 - sub;
        res.speed = 12'(9830400 / per);
      end
      held_period = 16'(per);
      res.awake = 1'b1;
      if (mode == stp_pkg::MODE_FWD) begin
        coils = full_step_coils(fwd_phase);
        fwd_phase = fwd_phase - 2'd1;
      end else begin
        coils = full_step_coils(rev_phase);
        rev_phase = rev_phase + 2'd1;
      end
    end
    res.a_in1 = coils[3];
    res.a_in2 = coils[2];
    res.b_in1 = coils[1];
    res.b_in2 = coils[0];
    res.period = held_period;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    if (mismatch_count <= 30)
      $display("mismatch on result %0d: %s got %0d expected %0d",
               results_seen, what, got, want);
  endtask

  task automatic push_tick(input logic [1:0] mode, input logic [11:0] sample,
                           input bit drain_first);
    step_tick_t t;
    t.mode = mode;
    t.sample = sample;
    t.drain_first = drain_first;
    pending_ticks.push_back(t);
  endtask

  // random ticks: mostly driving steps, some idle and spare mode, samples near the edges or anywhere in range
  task automatic push_random_ticks(input int unsigned count);
    logic [1:0]  mode;
    logic [11:0] sample;
    int unsigned pick;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) mode = stp_pkg::MODE_IDLE;
      else if (pick == 1) mode = MODE_SPARE;
      else if (pick < 6) mode = stp_pkg::MODE_FWD;
      else mode = stp_pkg::MODE_REV;
      case ($urandom_range(0, 3))
        0: sample = 12'($urandom_range(0, 120));
        1: sample = 12'($urandom_range(3250, 3350));
        default: sample = 12'($urandom_range(0, 4095));
      endcase
      push_tick(mode, sample, (i == 0) || ($urandom_range(0, 24) == 0));
    end
  endtask

  task automatic wait_all_done();
    while (pending_ticks.size() != 0 || expected_drive.size() != 0) @(negedge clk);
  endtask

  // input driver: offers the head of the pending queue, predicts on acceptance
  always @(posedge clk) begin : tick_driver
    bit busy;
    bit go;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      busy = s_tvalid;
      if (s_tvalid && s_tready) begin
        expected_drive.push_back(predict_drive(s_tuser, s_tdata[11:0]));
        void'(pending_ticks.pop_front());
        busy = 1'b0;
      end
      if (!busy) begin
        go = (pending_ticks.size() != 0) && ($urandom_range(0, 99) >= tx_gap_pct);
        if (go && pending_ticks[0].drain_first && expected_drive.size() != 0) go = 1'b0;
        if (go) begin
          s_tvalid <= 1'b1;
          s_tuser <= pending_ticks[0].mode;
          s_tdata <= {4'b0000, pending_ticks[0].sample};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (rst) begin
      rx_hold_left <= 0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_hold_taken != rx_hold_requests) begin
      rx_hold_left <= LONG_HOLD;
      rx_hold_taken <= rx_hold_requests;
    end
  end

  // result monitor: compares each accepted beat with the oldest expectation
  always @(posedge clk) begin : result_monitor
    drive_out_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_drive.size() == 0) begin
          report_mismatch("result beat with nothing expected", 1, 0);
        end else begin
          want = expected_drive.pop_front();
          if (m_tdata[0] !== want.a_in1) report_mismatch("coil_a_in1", m_tdata[0], want.a_in1);
          if (m_tdata[1] !== want.a_in2) report_mismatch("coil_a_in2", m_tdata[1], want.a_in2);
          if (m_tdata[2] !== want.b_in1) report_mismatch("coil_b_in1", m_tdata[2], want.b_in1);
          if (m_tdata[3] !== want.b_in2) report_mismatch("coil_b_in2", m_tdata[3], want.b_in2);
          if (m_tdata[4] !== want.awake)
            report_mismatch("driver_awake", m_tdata[4], want.awake);
          if (m_tdata[20:5] !== want.period)
            report_mismatch("step_period", m_tdata[20:5], want.period);
          if (m_tdata[32:21] !== want.speed)
            report_mismatch("speed_rpm_x100", m_tdata[32:21], want.speed);
        end
      end
      m_tready <= (rx_hold_left == 0) && ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // stimulus sequence and end of run
  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: idle at reset, period and speed edges, both wraps, spare mode
    push_tick(stp_pkg::MODE_IDLE, 12'd0, 1'b0);
    push_tick(MODE_SPARE, 12'd4095, 1'b0);
    push_tick(stp_pkg::MODE_FWD, 12'd0, 1'b0);
    push_tick(stp_pkg::MODE_FWD, 12'd79, 1'b0);
    push_tick(stp_pkg::MODE_FWD, 12'd80, 1'b0);
    push_tick(stp_pkg::MODE_FWD, 12'd89, 1'b0);
    push_tick(stp_pkg::MODE_FWD, 12'd90, 1'b0);
    push_tick(stp_pkg::MODE_IDLE, 12'd1234, 1'b0);
    push_tick(stp_pkg::MODE_REV, 12'd3309, 1'b0);
    push_tick(stp_pkg::MODE_REV, 12'd3310, 1'b0);
    push_tick(stp_pkg::MODE_REV, 12'd4095, 1'b0);
    push_tick(stp_pkg::MODE_REV, 12'd2048, 1'b0);
    push_tick(stp_pkg::MODE_REV, 12'd1, 1'b0);
    push_tick(MODE_SPARE, 12'd0, 1'b0);
    push_tick(stp_pkg::MODE_FWD, 12'd1365, 1'b0);
    push_tick(stp_pkg::MODE_FWD, 12'd2730, 1'b0);
    push_tick(stp_pkg::MODE_FWD, 12'd4095, 1'b0);
    push_tick(stp_pkg::MODE_IDLE, 12'd4095, 1'b0);
    push_tick(stp_pkg::MODE_REV, 12'd1000, 1'b0);
    push_tick(stp_pkg::MODE_FWD, 12'd100, 1'b0);
    push_tick(stp_pkg::MODE_FWD, 12'd2457, 1'b1);
    push_tick(stp_pkg::MODE_IDLE, 12'd0, 1'b0);

    // sender idles less than the receiver
    push_random_ticks(150);
    wait_all_done();

    // receiver idles less than the sender
    tx_gap_pct = 55;
    rx_stall_pct = 28;
    push_random_ticks(150);
    wait_all_done();

    // no idling, opened by a long receiver hold-off that backs up the input
    tx_gap_pct = 0;
    rx_stall_pct = 0;
    rx_hold_requests++;
    push_random_ticks(150);
    wait_all_done();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // run limit
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
